/* hdl/llpe_pkg.sv */
// Shared types and constants of the linked-list pool engine.
package llpe_pkg;

  localparam int KIND_W  = 2;
  localparam int HEAD_W  = 5;
  localparam int VALUE_W = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_CONCAT = 2'd1,
    KIND_WALK   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CHASE,
    ST_LINK
  } state_e;

  typedef enum logic [1:0] {
    HEAD_FIRST,
    HEAD_SECOND,
    HEAD_NEW,
    HEAD_CUR
  } head_sel_e;

  typedef struct packed {
    logic      load;
    logic      advance;
    logic      wr_node;
    logic      wr_tail;
    logic      link_to_second;
    logic      inc_count;
    logic      emit;
    head_sel_e head_sel;
    logic      res_empty;
    logic      res_value;
    logic      res_full;
    logic      res_loop;
    logic      res_last;
  } ctrl_t;

  typedef struct packed {
    kind_e kind;
    logic  e1;
    logic  e2;
    logic  full;
    logic  has_next;
    logic  at_limit;
  } stat_t;

endpackage

/* hdl/linked_list_pool_engine_core.sv */
// Top level of the linked-list pool engine.
//
// A request is taken when start is high and busy is low; busy stays high until the
// request is finished. The node pool is read through registered-read RAMs, one link
// per clock. Append to a non-empty list with room and concatenation of two non-empty
// lists follow the first list to its tail, then write the link; a walk produces one
// result per clock. Empty operands and a full pool end in the decide state, and kind 3
// ends there with no result. Busy falls before the next request can be taken.
// Each result shows on the outputs for exactly one cycle with result_valid_o high,
// in the cycle after it is formed; there is no backpressure, so the receiver must take
// every result as it comes. last_o marks the final result of each request. Every
// tail search and walk gives up after POOL_SIZE nodes and reports loop_found_o.
module linked_list_pool_engine_core #(
  parameter int POOL_SIZE  = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [llpe_pkg::KIND_W-1:0]         kind_i,
  input  logic [llpe_pkg::HEAD_W-1:0]         first_head_i,
  input  logic                                first_empty_i,
  input  logic [llpe_pkg::HEAD_W-1:0]         second_head_i,
  input  logic                                second_empty_i,
  input  logic signed [llpe_pkg::VALUE_W-1:0] value_i,
  output logic                                result_valid_o,
  output logic [llpe_pkg::HEAD_W-1:0]         result_head_o,
  output logic                                result_empty_o,
  output logic signed [llpe_pkg::VALUE_W-1:0] node_value_o,
  output logic                                pool_full_o,
  output logic                                loop_found_o,
  output logic                                last_o
);
  import llpe_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  llpe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  llpe_dp #(
    .POOL_SIZE  (POOL_SIZE),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .kind_i         (kind_i),
    .first_head_i   (first_head_i),
    .first_empty_i  (first_empty_i),
    .second_head_i  (second_head_i),
    .second_empty_i (second_empty_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .result_head_o  (result_head_o),
    .result_empty_o (result_empty_o),
    .node_value_o   (node_value_o),
    .pool_full_o    (pool_full_o),
    .loop_found_o   (loop_found_o),
    .last_o         (last_o)
  );

endmodule

/* hdl/llpe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module llpe_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/llpe_ctrl.sv */
// Request sequencer of the linked-list pool engine.
module llpe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  llpe_pkg::stat_t stat_i,
  output llpe_pkg::ctrl_t ctrl_o
);
  import llpe_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        unique case (stat_i.kind)
          KIND_APPEND: begin
            state_d = (stat_i.full || stat_i.e1) ? ST_IDLE : ST_CHASE;
          end
          KIND_CONCAT: begin
            state_d = (stat_i.e1 || stat_i.e2) ? ST_IDLE : ST_CHASE;
          end
          KIND_WALK: begin
            state_d = stat_i.e1 ? ST_IDLE : ST_CHASE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_CHASE: begin
        if (stat_i.kind == KIND_WALK) begin
          if (!stat_i.has_next || stat_i.at_limit) begin
            state_d = ST_IDLE;
          end
        end else if (!stat_i.has_next) begin
          state_d = ST_LINK;
        end else if (stat_i.at_limit) begin
          state_d = ST_IDLE;
        end
      end
      ST_LINK: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.head_sel = HEAD_FIRST;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.load = start;
      end
      ST_DECIDE: begin
        unique case (stat_i.kind)
          KIND_APPEND: begin
            if (stat_i.full) begin
              ctrl_o.emit      = 1'b1;
              ctrl_o.res_empty = stat_i.e1;
              ctrl_o.res_full  = 1'b1;
              ctrl_o.res_last  = 1'b1;
            end else if (stat_i.e1) begin
              // empty list: the new node is the whole list
              ctrl_o.wr_node   = 1'b1;
              ctrl_o.inc_count = 1'b1;
              ctrl_o.emit      = 1'b1;
              ctrl_o.head_sel  = HEAD_NEW;
              ctrl_o.res_last  = 1'b1;
            end
          end
          KIND_CONCAT: begin
            if (stat_i.e1) begin
              ctrl_o.emit      = 1'b1;
              ctrl_o.head_sel  = HEAD_SECOND;
              ctrl_o.res_empty = stat_i.e2;
              ctrl_o.res_last  = 1'b1;
            end else if (stat_i.e2) begin
              ctrl_o.emit     = 1'b1;
              ctrl_o.res_last = 1'b1;
            end
          end
          KIND_WALK: begin
            if (stat_i.e1) begin
              ctrl_o.emit      = 1'b1;
              ctrl_o.res_empty = 1'b1;
              ctrl_o.res_last  = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_CHASE: begin
        if (stat_i.kind == KIND_WALK) begin
          ctrl_o.emit      = 1'b1;
          ctrl_o.head_sel  = HEAD_CUR;
          ctrl_o.res_value = 1'b1;
          ctrl_o.res_loop  = stat_i.has_next && stat_i.at_limit;
          ctrl_o.res_last  = !stat_i.has_next || stat_i.at_limit;
          ctrl_o.advance   = stat_i.has_next && !stat_i.at_limit;
        end else if (!stat_i.has_next) begin
          // tail found; append stores its node now, the tail link follows
          ctrl_o.wr_node = (stat_i.kind == KIND_APPEND);
        end else if (stat_i.at_limit) begin
          ctrl_o.emit     = 1'b1;
          ctrl_o.res_loop = 1'b1;
          ctrl_o.res_last = 1'b1;
        end else begin
          ctrl_o.advance = 1'b1;
        end
      end
      ST_LINK: begin
        ctrl_o.wr_tail        = 1'b1;
        ctrl_o.link_to_second = (stat_i.kind != KIND_APPEND);
        ctrl_o.inc_count      = (stat_i.kind == KIND_APPEND);
        ctrl_o.emit           = 1'b1;
        ctrl_o.res_last       = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* hdl/llpe_dp.sv */
// Datapath of the linked-list pool engine: node pool, pointers and result registers.
module llpe_dp #(
  parameter int POOL_SIZE  = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  llpe_pkg::ctrl_t                     ctrl_i,
  output llpe_pkg::stat_t                     stat_o,
  input  logic [llpe_pkg::KIND_W-1:0]         kind_i,
  input  logic [llpe_pkg::HEAD_W-1:0]         first_head_i,
  input  logic                                first_empty_i,
  input  logic [llpe_pkg::HEAD_W-1:0]         second_head_i,
  input  logic                                second_empty_i,
  input  logic signed [llpe_pkg::VALUE_W-1:0] value_i,
  output logic                                result_valid_o,
  output logic [llpe_pkg::HEAD_W-1:0]         result_head_o,
  output logic                                result_empty_o,
  output logic signed [llpe_pkg::VALUE_W-1:0] node_value_o,
  output logic                                pool_full_o,
  output logic                                loop_found_o,
  output logic                                last_o
);
  import llpe_pkg::*;

  localparam int IdxW  = $clog2(POOL_SIZE);
  localparam int CntW  = $clog2(POOL_SIZE + 1);
  localparam int LinkW = IdxW + 1;
  localparam int CmpW  = (CntW > HEAD_W) ? CntW : HEAD_W;

  // request registers
  kind_e                 kind_q;
  logic [HEAD_W-1:0]     head1_q, head2_q;
  logic                  e1_q, e2_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [IdxW-1:0]       cur_q, cur_d;
  logic [IdxW-1:0]       step_q, step_d;
  logic [CntW-1:0]       count_q, count_d;

  // result registers
  logic                     res_valid_q;
  logic [HEAD_W-1:0]        res_head_q, res_head_d;
  logic                     res_empty_q;
  logic signed [VALUE_W-1:0] res_value_q, res_value_d;
  logic                     res_full_q, res_loop_q, res_last_q;

  logic                  live1, live2;
  logic [IdxW-1:0]       new_idx, rd_addr, link_idx, link_target;
  logic                  link_valid;
  logic [DATA_WIDTH-1:0] data_rdata;
  logic [LinkW-1:0]      link_rdata, link_wdata;
  logic [IdxW-1:0]       link_waddr;
  logic [HEAD_W-1:0]     head_mux;

  // a head at or above the fill level names no list
  assign live1 = CmpW'(first_head_i) < CmpW'(count_q);
  assign live2 = CmpW'(second_head_i) < CmpW'(count_q);

  assign new_idx    = IdxW'(count_q);
  assign link_valid = link_rdata[IdxW];
  assign link_idx   = link_rdata[IdxW-1:0];

  assign stat_o.kind     = kind_q;
  assign stat_o.e1       = e1_q;
  assign stat_o.e2       = e2_q;
  assign stat_o.full     = (count_q == CntW'(POOL_SIZE));
  assign stat_o.has_next = link_valid && (CntW'(link_idx) < count_q);
  assign stat_o.at_limit = (step_q == IdxW'(POOL_SIZE - 1));

  // read data always belongs to cur_q, one node per cycle while chasing
  always_comb begin
    if (ctrl_i.load) begin
      rd_addr = IdxW'(first_head_i);
    end else if (ctrl_i.advance) begin
      rd_addr = link_idx;
    end else begin
      rd_addr = cur_q;
    end
  end

  always_comb begin
    cur_d  = cur_q;
    step_d = step_q;
    if (ctrl_i.load) begin
      cur_d  = IdxW'(first_head_i);
      step_d = '0;
    end else if (ctrl_i.advance) begin
      cur_d  = link_idx;
      step_d = step_q + 1'b1;
    end
  end

  assign count_d = ctrl_i.inc_count ? count_q + 1'b1 : count_q;

  assign link_target = ctrl_i.link_to_second ? IdxW'(head2_q) : new_idx;
  assign link_waddr  = ctrl_i.wr_tail ? cur_q : new_idx;
  assign link_wdata  = ctrl_i.wr_tail ? {1'b1, link_target} : '0;

  llpe_ram #(
    .Width (DATA_WIDTH),
    .Depth (POOL_SIZE)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_node),
    .waddr_i (new_idx),
    .wdata_i (val_q),
    .raddr_i (rd_addr),
    .rdata_o (data_rdata)
  );

  llpe_ram #(
    .Width (LinkW),
    .Depth (POOL_SIZE)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_node | ctrl_i.wr_tail),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (rd_addr),
    .rdata_o (link_rdata)
  );

  always_comb begin
    unique case (ctrl_i.head_sel)
      HEAD_FIRST:  head_mux = head1_q;
      HEAD_SECOND: head_mux = head2_q;
      HEAD_NEW:    head_mux = HEAD_W'(new_idx);
      HEAD_CUR:    head_mux = HEAD_W'(cur_q);
      default:     head_mux = head1_q;
    endcase
  end

  assign res_head_d  = ctrl_i.res_empty ? '0 : head_mux;
  assign res_value_d = ctrl_i.res_value ? VALUE_W'($signed(data_rdata)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= ctrl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    step_q <= step_d;
    if (ctrl_i.load) begin
      kind_q  <= kind_e'(kind_i);
      head1_q <= first_head_i;
      head2_q <= second_head_i;
      e1_q    <= first_empty_i | !live1;
      e2_q    <= second_empty_i | !live2;
      val_q   <= DATA_WIDTH'(value_i);
    end
    if (ctrl_i.emit) begin
      res_head_q  <= res_head_d;
      res_empty_q <= ctrl_i.res_empty;
      res_value_q <= res_value_d;
      res_full_q  <= ctrl_i.res_full;
      res_loop_q  <= ctrl_i.res_loop;
      res_last_q  <= ctrl_i.res_last;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_head_o  = res_head_q;
  assign result_empty_o = res_empty_q;
  assign node_value_o   = res_value_q;
  assign pool_full_o    = res_full_q;
  assign loop_found_o   = res_loop_q;
  assign last_o         = res_last_q;

endmodule

/* hdl/llpe_chk.sv */
// Port-level checker of the linked-list pool engine and its bind.
module llpe_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                result_valid_o,
  input logic [llpe_pkg::HEAD_W-1:0]         result_head_o,
  input logic                                result_empty_o,
  input logic signed [llpe_pkg::VALUE_W-1:0] node_value_o,
  input logic                                pool_full_o,
  input logic                                loop_found_o,
  input logic                                last_o
);

  // a taken transaction makes the engine busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("engine not busy after taking a transaction");

  // results are formed only while a request is in flight
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a request in flight");

  // a walk that is not finished keeps the engine busy
  a_more_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("non-final result while idle");

  a_flags_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (pool_full_o || loop_found_o) |-> last_o)
    else $error("pool full or loop flag on a non-final result");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_empty_o |-> (result_head_o == '0) && (node_value_o == '0))
    else $error("empty result carries a head or value");

endmodule

bind linked_list_pool_engine_core llpe_chk u_llpe_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_head_o  (result_head_o),
  .result_empty_o (result_empty_o),
  .node_value_o   (node_value_o),
  .pool_full_o    (pool_full_o),
  .loop_found_o   (loop_found_o),
  .last_o         (last_o)
);
